[hdl/touch_button_hit_test_top_assert.svh]
// Assertion macros for the touch button hit test block.
// Used by touch_button_hit_test_top; relies on clk_i and rst_ni in the including module.
`ifndef TOUCH_BUTTON_HIT_TEST_TOP_ASSERT_SVH
`define TOUCH_BUTTON_HIT_TEST_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tbht_pkg.sv]
// Shared types and constants for the touch button hit test block.
// No dependencies; imported by every module of the block.
package tbht_pkg;

  localparam int COORD_W = 16;
  localparam int RAW_W   = 12;
  localparam int SCALE_W = 10;
  localparam int ID_W    = 8;
  localparam int LANES   = 2;

  // Calibration arithmetic widths.
  localparam int DIFF_W  = RAW_W + 1;
  localparam int NUM_W   = 24;
  localparam int MAG_W   = NUM_W - 1;
  localparam int RECIP_W = 21;
  localparam int FRAC_W  = 32;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int Q_W     = 12;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RAW_W-1:0]          raw_t;
  typedef logic [SCALE_W-1:0]        scale_t;
  typedef logic [ID_W-1:0]           id_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [NUM_W-1:0]   num_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [PROD_W-1:0]         prod_t;
  typedef logic [Q_W-1:0]            quot_t;
  typedef logic [RECIP_W-1:0]        recip_t;

  // Lane 0 is x, lane 1 is y. The x divisor is negative, so its sign is folded in.
  localparam diff_t  CAL_ZERO [LANES] = '{13'sd3800, 13'sd100};
  localparam quot_t  DIVISOR  [LANES] = '{12'd3700, 12'd3650};
  localparam recip_t RECIP    [LANES] = '{
    RECIP_W'((64'd1 << FRAC_W) / 64'd3700),
    RECIP_W'((64'd1 << FRAC_W) / 64'd3650)
  };
  localparam logic [LANES-1:0] DIV_NEG = 2'b01;

  localparam scale_t WIDTH_RESET  = 10'd240;
  localparam scale_t HEIGHT_RESET = 10'd320;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAP,
    S_SEARCH,
    S_FINISH
  } state_e;

  typedef struct packed {
    cmd_e   cmd;
    logic   touched;
    raw_t   raw_x;
    raw_t   raw_y;
    id_t    button_code;
    coord_t left_edge;
    coord_t top_edge;
    coord_t right_edge;
    coord_t bottom_edge;
  } in_item_t;

  typedef struct packed {
    id_t     pressed_id;
    logic    new_press;
    coord_t  mapped_x;
    coord_t  mapped_y;
    status_e status;
  } out_item_t;

  typedef struct packed {
    id_t    id;
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } entry_t;

  // Running result handed from cell to cell along the row.
  typedef struct packed {
    logic found;
    id_t  id;
  } carry_t;

  typedef struct packed {
    logic add;
    logic shift;
    logic rect_mode;
  } cell_ctrl_t;

endpackage

[hdl/tbht_map.sv]
// Calibration pipeline: maps raw x and y readings to screen coordinates.
// Four stages per lane; division by a constant via reciprocal and one correction. Uses tbht_pkg.
module tbht_map (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  tbht_pkg::raw_t   raw_x_i,
  input  tbht_pkg::raw_t   raw_y_i,
  input  tbht_pkg::scale_t width_i,
  input  tbht_pkg::scale_t height_i,
  output logic            valid_o,
  output tbht_pkg::coord_t x_o,
  output tbht_pkg::coord_t y_o
);
  import tbht_pkg::*;

  raw_t   raw   [LANES];
  scale_t scale [LANES];
  diff_t  diff  [LANES];
  num_t   num_d [LANES];
  quot_t  q0    [LANES];
  mag_t   rem   [LANES];
  coord_t quo   [LANES];

  num_t   num_q  [LANES];
  mag_t   mag_q  [LANES];
  logic   neg_q  [LANES];
  prod_t  prod_q [LANES];
  mag_t   mag2_q [LANES];
  logic   neg2_q [LANES];
  coord_t res_q  [LANES];

  logic [3:0] v_q;

  always_comb begin
    raw[0]   = raw_x_i;
    raw[1]   = raw_y_i;
    scale[0] = width_i;
    scale[1] = height_i;
    for (int l = 0; l < LANES; l++) begin
      diff[l]  = $signed({1'b0, raw[l]}) - CAL_ZERO[l];
      num_d[l] = num_t'(diff[l]) * num_t'($signed({1'b0, scale[l]}));
      q0[l]    = prod_q[l][FRAC_W +: Q_W];
      rem[l]   = mag2_q[l] - mag_t'(q0[l]) * mag_t'(DIVISOR[l]);
      quo[l]   = (rem[l] >= mag_t'(DIVISOR[l])) ? coord_t'(q0[l]) + coord_t'(1)
                                                 : coord_t'(q0[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      num_q[l]  <= num_d[l];
      mag_q[l]  <= mag_t'(num_q[l][NUM_W-1] ? -num_q[l] : num_q[l]);
      neg_q[l]  <= DIV_NEG[l] ? !num_q[l][NUM_W-1] : num_q[l][NUM_W-1];
      prod_q[l] <= prod_t'(mag_q[l]) * prod_t'(RECIP[l]);
      mag2_q[l] <= mag_q[l];
      neg2_q[l] <= neg_q[l];
      res_q[l]  <= neg2_q[l] ? -quo[l] : quo[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], start_i};
    end
  end

  assign valid_o = v_q[3];
  assign x_o     = res_q[0];
  assign y_o     = res_q[1];

endmodule

[hdl/tbht_cell.sv]
// One table slot: holds a button entry and passes a running search result to its neighbour.
// Uses tbht_pkg.
module tbht_cell #(
  parameter int Idx  = 0,
  parameter int CntW = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tbht_pkg::cell_ctrl_t ctrl_i,
  input  logic [CntW-1:0]      count_i,
  input  tbht_pkg::id_t        code_i,
  input  tbht_pkg::coord_t     px_i,
  input  tbht_pkg::coord_t     py_i,
  input  tbht_pkg::entry_t     add_entry_i,
  input  tbht_pkg::entry_t     next_entry_i,
  input  tbht_pkg::carry_t     carry_i,
  output tbht_pkg::entry_t     entry_o,
  output tbht_pkg::carry_t     carry_o
);
  import tbht_pkg::*;

  entry_t entry_q;
  carry_t carry_q;
  carry_t carry_d;
  logic   active;
  logic   hit;
  logic   match;

  always_comb begin
    active = count_i > CntW'(Idx);
    hit    = (entry_q.left <= px_i) && (entry_q.top <= py_i) &&
             (entry_q.right >= px_i) && (entry_q.bottom >= py_i);
    match  = active && (ctrl_i.rect_mode ? hit : (entry_q.id == code_i));
    carry_d.found = carry_i.found | match;
    carry_d.id    = match ? entry_q.id : carry_i.id;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  // A removal closes up the gap: every slot at or after the match takes its neighbour.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.add && (count_i == CntW'(Idx))) begin
      entry_q <= add_entry_i;
    end else if (ctrl_i.shift && carry_q.found) begin
      entry_q <= next_entry_i;
    end
  end

  assign entry_o = entry_q;
  assign carry_o = carry_q;

endmodule

[hdl/touch_button_hit_test_top.sv]
// Top level of the touch button hit test block.
// Depends on tbht_pkg, tbht_map, tbht_cell and touch_button_hit_test_top_assert.svh.
//
// Items are accepted when start is high and busy is low; every item gives exactly one
// result, shown for a single cycle with result_valid_o high, and the receiver cannot
// hold it off, so it must be taken in that cycle. Button adds, clears and touch samples
// that are not a new press show their result in the cycle after they are accepted. A
// removal searches the row of table cells, one cell per cycle, and a new press first
// passes the four-stage calibration pipeline and then searches the row too.
// The next item may be accepted in the cycle in which the previous result is shown.
// The screen size registers are written through the cfg port, which is always ready;
// they should only be written while the block is idle.
module touch_button_hit_test_top #(
  parameter int MAX_BUTTONS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tbht_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output tbht_pkg::out_item_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [9:0]          cfg_wdata_i
);
  import tbht_pkg::*;

  localparam int CntW  = $clog2(MAX_BUTTONS + 1);
  localparam int WaitW = $clog2(MAX_BUTTONS);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [WaitW-1:0] wait_q, wait_d;
  logic            handled_q, handled_d;
  logic            rect_mode_q, rect_mode_d;
  id_t             code_q, code_d;
  coord_t          px_q, px_d, py_q, py_d;
  scale_t          width_q, height_q;
  out_item_t       result_q, result_d;
  logic            result_valid_q, result_valid_d;

  logic            accept;
  logic            map_start;
  logic            map_valid;
  coord_t          map_x, map_y;
  cell_ctrl_t      ctrl;
  entry_t          add_entry;
  entry_t          ents  [MAX_BUTTONS];
  carry_t          chain [MAX_BUTTONS+1];

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Screen size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tbht_map u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (map_start),
    .raw_x_i  (item_i.raw_x),
    .raw_y_i  (item_i.raw_y),
    .width_i  (width_q),
    .height_i (height_q),
    .valid_o  (map_valid),
    .x_o      (map_x),
    .y_o      (map_y)
  );

  // The entry being added comes straight from the accepted item.
  always_comb begin
    add_entry.id     = item_i.button_code;
    add_entry.left   = item_i.left_edge;
    add_entry.top    = item_i.top_edge;
    add_entry.right  = item_i.right_edge;
    add_entry.bottom = item_i.bottom_edge;
  end

  // The row of cells. Slot 0 is the oldest entry; the search result flows towards the
  // last slot, so a later hit overrides an earlier one and the first match of a removal
  // marks itself and every slot after it for closing up.
  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_BUTTONS; g++) begin : g_cell
    entry_t nxt;
    if (g == MAX_BUTTONS - 1) begin : g_last
      assign nxt = ents[g];
    end else begin : g_mid
      assign nxt = ents[g+1];
    end

    tbht_cell #(
      .Idx  (g),
      .CntW (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .code_i       (code_q),
      .px_i         (px_q),
      .py_i         (py_q),
      .add_entry_i  (add_entry),
      .next_entry_i (nxt),
      .carry_i      (chain[g]),
      .entry_o      (ents[g]),
      .carry_o      (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      wait_q         <= '0;
      handled_q      <= 1'b0;
      rect_mode_q    <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      wait_q         <= wait_d;
      handled_q      <= handled_d;
      rect_mode_q    <= rect_mode_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    px_q     <= px_d;
    py_q     <= py_d;
    result_q <= result_d;
  end

  // Sequencer: one item at a time. Short commands finish in the accepting cycle; a
  // removal runs the search along the row, and a new press maps the point first.
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    wait_d         = wait_q;
    handled_d      = handled_q;
    rect_mode_d    = rect_mode_q;
    code_d         = code_q;
    px_d           = px_q;
    py_d           = py_q;
    result_d       = result_q;
    result_valid_d = 1'b0;
    map_start      = 1'b0;
    ctrl.add       = 1'b0;
    ctrl.shift     = 1'b0;
    ctrl.rect_mode = rect_mode_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          result_d = '0;
          unique case (item_i.cmd)
            CMD_SAMPLE: begin
              if (item_i.touched && !handled_q) begin
                map_start   = 1'b1;
                rect_mode_d = 1'b1;
                state_d     = S_MAP;
              end else begin
                if (!item_i.touched) begin
                  handled_d = 1'b0;
                end
                result_valid_d = 1'b1;
              end
            end
            CMD_ADD: begin
              if (count_q < CntW'(MAX_BUTTONS)) begin
                ctrl.add = 1'b1;
                count_d  = count_q + CntW'(1);
              end else begin
                result_d.status = ST_FULL;
              end
              result_valid_d = 1'b1;
            end
            CMD_REMOVE: begin
              code_d      = item_i.button_code;
              rect_mode_d = 1'b0;
              wait_d      = WaitW'(MAX_BUTTONS - 1);
              state_d     = S_SEARCH;
            end
            CMD_CLEAR: begin
              count_d        = '0;
              result_valid_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_MAP: begin
        if (map_valid) begin
          px_d    = map_x;
          py_d    = map_y;
          wait_d  = WaitW'(MAX_BUTTONS - 1);
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // The search inputs are held steady while the result passes from cell to cell,
        // until the last carry is settled.
        if (wait_q == '0) begin
          state_d = S_FINISH;
        end else begin
          wait_d = wait_q - WaitW'(1);
        end
      end
      S_FINISH: begin
        result_d = '0;
        if (rect_mode_q) begin
          result_d.pressed_id = chain[MAX_BUTTONS].id;
          result_d.new_press  = 1'b1;
          result_d.mapped_x   = px_q;
          result_d.mapped_y   = py_q;
          handled_d           = 1'b1;
        end else if (chain[MAX_BUTTONS].found) begin
          ctrl.shift = 1'b1;
          count_d    = count_q - CntW'(1);
        end else begin
          result_d.status = ST_NOT_FOUND;
        end
        result_valid_d = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  `include "touch_button_hit_test_top_assert.svh"

  // The table never holds more entries than it has cells.
  `TBHT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(MAX_BUTTONS), "entry count beyond table size")
  // A result appears only after an accepted short command or the end of a search.
  `TBHT_ASSERT_NOW(a_strobe_source, result_valid_q, $past(accept) || $past(state_q == S_FINISH), "result without a cause")
  // Reporting a new press marks the press as handled.
  `TBHT_ASSERT_NOW(a_press_flag, result_valid_q && result_q.new_press, handled_q, "new press left unhandled")
  // A successful removal shrinks the table by exactly one entry.
  `TBHT_ASSERT_NEXT(a_remove_shrinks, state_q == S_FINISH && !rect_mode_q && chain[MAX_BUTTONS].found, count_q == $past(count_q) - CntW'(1), "removal did not shrink the table")

endmodule

[dv/tb_touch_button_hit_test_top.sv]
// Self-checking testbench for touch_button_hit_test_top: directed rows, then constrained-free
// random traffic on varied screen sizes; results checked against typed rows or a bench model.
// Depends only on tbht_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_touch_button_hit_test_top;
  import tbht_pkg::*;

  // Table depth given to the block; the model keeps the same number of slots.
  localparam int TABLE_DEPTH = 16;

  // Calibration points of the two axes: the raw reading at mapped 0 and at full scale.
  localparam longint X_AT_ZERO = 3800;
  localparam longint X_AT_FULL = 100;
  localparam longint Y_AT_ZERO = 100;
  localparam longint Y_AT_FULL = 3750;

  // Register indexes beyond the two real registers; writes to them must be dropped.
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  localparam coord_t COORD_MIN = 16'h8000;
  localparam coord_t COORD_MAX = 16'h7fff;

  // Random items per phase; six phases plus the directed rows give about a thousand items.
  localparam int unsigned PHASE_ITEMS = 160;
  // Cycles without any handshake before the run is declared hung. The slowest item, a new
  // press, is mapped and then searched, and sender gaps are short, so this is ample.
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct {
    in_item_t    stim;
    int unsigned reps;
    bit          fixed;
    out_item_t   outcome;
  } drill_row_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   stim = '0;
  logic       result_valid;
  out_item_t  result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  scale_t     cfg_wdata = '0;

  // Model state: the button table, the press latch and the two screen size registers.
  entry_t      btn_table [TABLE_DEPTH];
  int unsigned btn_count = 0;
  bit          press_latched = 1'b0;
  scale_t      scr_width = WIDTH_RESET;
  scale_t      scr_height = HEIGHT_RESET;

  out_item_t   awaited_outcomes [$];
  drill_row_t  drills [$];
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned fault_count = 0;
  int unsigned idle_pct = 25;
  int unsigned quiet_cycles = 0;

  touch_button_hit_test_top #(
    .MAX_BUTTONS(TABLE_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (stim),
    .result_valid_o(result_valid),
    .result_o      (result),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the result of one accepted item and moves the model on by that item.
  // The mapping divides with truncation toward zero, which SystemVerilog division gives
  // directly on signed operands. The hit test keeps the last matching entry, so a later
  // rectangle overrides an earlier one, and an entry with id zero looks like a miss.
  function automatic out_item_t touch_outcome(in_item_t it);
    out_item_t r;
    longint    px, py;
    coord_t    hx, hy;
    int unsigned k;
    bit        located;
    r = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_SAMPLE: begin
        if (it.touched && !press_latched) begin
          px = (longint'(it.raw_x) - X_AT_ZERO) * longint'(scr_width) / (X_AT_FULL - X_AT_ZERO);
          py = (longint'(it.raw_y) - Y_AT_ZERO) * longint'(scr_height) / (Y_AT_FULL - Y_AT_ZERO);
          hx = px[COORD_W-1:0];
          hy = py[COORD_W-1:0];
          r.new_press = 1'b1;
          r.mapped_x = hx;
          r.mapped_y = hy;
          for (k = 0; k < btn_count; k++) begin
            if ($signed(btn_table[k].left) <= hx && $signed(btn_table[k].top) <= hy &&
                $signed(btn_table[k].right) >= hx && $signed(btn_table[k].bottom) >= hy) begin
              r.pressed_id = btn_table[k].id;
            end
          end
          press_latched = 1'b1;
        end else if (!it.touched) begin
          press_latched = 1'b0;
        end
      end
      CMD_ADD: begin
        if (btn_count < TABLE_DEPTH) begin
          btn_table[btn_count] = '{id: it.button_code, left: it.left_edge, top: it.top_edge,
                                   right: it.right_edge, bottom: it.bottom_edge};
          btn_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        located = 1'b0;
        for (k = 0; k < btn_count; k++) begin
          if (btn_table[k].id == it.button_code) begin
            located = 1'b1;
            break;
          end
        end
        if (located) begin
          // Later entries close up by one place, keeping their order.
          while (k + 1 < btn_count) begin
            btn_table[k] = btn_table[k + 1];
            k++;
          end
          btn_count--;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      CMD_CLEAR: begin
        btn_count = 0;
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t mk(cmd_e c, logic t, raw_t x, raw_t y, id_t code,
                                  coord_t l, coord_t tp, coord_t rt, coord_t b);
    in_item_t it;
    it = '0;
    it.cmd = c;
    it.touched = t;
    it.raw_x = x;
    it.raw_y = y;
    it.button_code = code;
    it.left_edge = l;
    it.top_edge = tp;
    it.right_edge = rt;
    it.bottom_edge = b;
    return it;
  endfunction

  function automatic out_item_t res(id_t pid, logic np, coord_t mx, coord_t my, status_e st);
    out_item_t r;
    r.pressed_id = pid;
    r.new_press = np;
    r.mapped_x = mx;
    r.mapped_y = my;
    r.status = st;
    return r;
  endfunction

  function automatic void add_row(in_item_t s, int unsigned reps, bit fixed, out_item_t o);
    drill_row_t row;
    row.stim = s;
    row.reps = reps;
    row.fixed = fixed;
    row.outcome = o;
    drills.push_back(row);
  endfunction

  // Fully random bits in every field, the command included; callers override what they use.
  function automatic in_item_t noise_bits();
    logic [127:0] bits;
    in_item_t     it;
    bits = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = bits[$bits(in_item_t)-1:0];
    return it;
  endfunction

  // Mostly a small pool of ids so that duplicates and successful removals are common.
  function automatic id_t pick_code();
    if ($urandom_range(0, 3) == 0) begin
      return id_t'($urandom_range(0, 255));
    end
    return id_t'($urandom_range(0, 12));
  endfunction

  function automatic in_item_t sample_item(logic touch);
    in_item_t it;
    it = noise_bits();
    it.cmd = CMD_SAMPLE;
    it.touched = touch;
    return it;
  endfunction

  // Rectangles are mostly placed over the current screen so that presses land in them;
  // one in ten keeps the random edges, and a few are turned inside out.
  function automatic in_item_t add_item();
    in_item_t it;
    int       xs, ys, l, t;
    it = noise_bits();
    it.cmd = CMD_ADD;
    it.button_code = pick_code();
    if ($urandom_range(0, 9) != 0) begin
      xs = int'(scr_width) + 1;
      ys = int'(scr_height) + 1;
      l = int'($urandom_range(0, xs)) - 40;
      t = int'($urandom_range(0, ys)) - 40;
      it.left_edge = coord_t'(l);
      it.top_edge = coord_t'(t);
      it.right_edge = coord_t'(l + int'($urandom_range(0, xs / 2 + 8)));
      it.bottom_edge = coord_t'(t + int'($urandom_range(0, ys / 2 + 8)));
      if ($urandom_range(0, 19) == 0) begin
        {it.left_edge, it.right_edge} = {it.right_edge, it.left_edge};
      end
    end
    return it;
  endfunction

  // Presents one item from a falling edge and returns at the falling edge after it has been
  // taken. Start stays high between back-to-back items; it is only lowered for a gap.
  // A row with a typed expectation queues that instead of the model's answer, though the
  // model still steps so that its state follows the block.
  task automatic send_item(in_item_t it, bit fixed, out_item_t typed);
    out_item_t want;
    bit        accepted;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    stim <= it;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk_i);
      accepted = !busy;
    end
    want = touch_outcome(it);
    awaited_outcomes.push_back(fixed ? typed : want);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Holds the sender off until every queued result has come back.
  task automatic wait_quiet();
    start <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Leaves cfg_valid high so that consecutive writes need no drop in between.
  task automatic write_reg(logic [1:0] idx, scale_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_SCREEN_WIDTH) begin
      scr_width = val;
    end else if (idx == CFG_SCREEN_HEIGHT) begin
      scr_height = val;
    end
    @(negedge clk_i);
  endtask

  // Registers are only touched once the block has gone idle. Writes to the spare indexes
  // carry random data and must leave both sizes alone.
  task automatic set_screen(scale_t w, scale_t h, bit spare);
    wait_quiet();
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    if (spare) begin
      write_reg(CFG_SPARE_LO, scale_t'($urandom()));
      write_reg(CFG_SPARE_HI, scale_t'($urandom()));
    end
    cfg_valid <= 1'b0;
  endtask

  // Random traffic, built mostly from well-formed touch sequences (press, a few held
  // samples, release) and table edits against a table that is kept partly filled.
  task automatic run_traffic(int unsigned goal);
    in_item_t    it;
    int unsigned pick;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) begin
        wait_quiet();
      end
      if (pick < 40) begin
        if (press_latched) begin
          send_item(sample_item(1'b0), 1'b0, '0);
        end
        send_item(sample_item(1'b1), 1'b0, '0);
        repeat ($urandom_range(0, 2)) send_item(sample_item(1'b1), 1'b0, '0);
        if ($urandom_range(0, 4) != 0) begin
          send_item(sample_item(1'b0), 1'b0, '0);
        end
      end else if (pick < 65) begin
        send_item(add_item(), 1'b0, '0);
      end else if (pick < 80) begin
        it = noise_bits();
        it.cmd = CMD_REMOVE;
        if (btn_count != 0 && $urandom_range(0, 2) != 0) begin
          it.button_code = btn_table[$urandom_range(0, btn_count - 1)].id;
        end else begin
          it.button_code = pick_code();
        end
        send_item(it, 1'b0, '0);
      end else if (pick < 83) begin
        it = noise_bits();
        it.cmd = CMD_CLEAR;
        send_item(it, 1'b0, '0);
      end else if (pick < 88) begin
        // Fill the table to the brim, then try one more add to see it refused.
        while (btn_count < TABLE_DEPTH) send_item(add_item(), 1'b0, '0);
        send_item(add_item(), 1'b0, '0);
      end else begin
        send_item(noise_bits(), 1'b0, '0);
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    fault_count++;
    if (fault_count <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Results are strobed for one cycle and cannot be held off, so each one is taken at the
  // rising edge that ends its cycle and compared with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && result_valid) begin
      results_seen++;
      if (awaited_outcomes.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = awaited_outcomes.pop_front();
        if (result.pressed_id !== want.pressed_id) begin
          report_mismatch($sformatf("result %0d pressed_id got %0d expected %0d",
                                    results_seen, result.pressed_id, want.pressed_id));
        end
        if (result.new_press !== want.new_press) begin
          report_mismatch($sformatf("result %0d new_press got %0b expected %0b",
                                    results_seen, result.new_press, want.new_press));
        end
        if (result.mapped_x !== want.mapped_x) begin
          report_mismatch($sformatf("result %0d mapped_x got %0d expected %0d",
                                    results_seen, result.mapped_x, want.mapped_x));
        end
        if (result.mapped_y !== want.mapped_y) begin
          report_mismatch($sformatf("result %0d mapped_y got %0d expected %0d",
                                    results_seen, result.mapped_y, want.mapped_y));
        end
        if (result.status !== want.status) begin
          report_mismatch($sformatf("result %0d status got %0d expected %0d",
                                    results_seen, result.status, want.status));
        end
      end
    end
  end

  // Hang detector: any item, result or register write restarts the count.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned ph;

    // Directed rows, all at the reset screen size of 240 by 320.
    // Release straight after reset: nothing latched, all fields zero.
    add_row(mk(CMD_SAMPLE, 1'b0, 12'd0, 12'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_OK));
    // New press at the calibration origin on an empty table: point (0, 0), no hit.
    add_row(mk(CMD_SAMPLE, 1'b1, 12'd3800, 12'd100, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b1, res(8'd0, 1'b1, 16'sd0, 16'sd0, ST_OK));
    // Held touch reports nothing, whatever the readings.
    add_row(mk(CMD_SAMPLE, 1'b1, 12'd0, 12'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_OK));
    add_row(mk(CMD_SAMPLE, 1'b0, 12'd4095, 12'd4095, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_OK));
    // Removal from an empty table cannot find its id.
    add_row(mk(CMD_REMOVE, 1'b0, 12'd0, 12'd0, 8'd7, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_NOT_FOUND));
    add_row(mk(CMD_ADD, 1'b0, 12'd0, 12'd0, 8'd255, 16'sd0, 16'sd0, 16'sd240, 16'sd320),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_OK));
    // Id zero over the whole coordinate range: it wins the hit but reads as no hit.
    add_row(mk(CMD_ADD, 1'b0, 12'd0, 12'd0, 8'd0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_OK));
    add_row(mk(CMD_SAMPLE, 1'b1, 12'd100, 12'd3750, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b0, '0);
    add_row(mk(CMD_SAMPLE, 1'b0, 12'd0, 12'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b0, '0);
    add_row(mk(CMD_REMOVE, 1'b0, 12'd0, 12'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_OK));
    // Full-scale corner lands exactly on the inclusive edges of id 255.
    add_row(mk(CMD_SAMPLE, 1'b1, 12'd100, 12'd3750, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b0, '0);
    add_row(mk(CMD_SAMPLE, 1'b0, 12'd0, 12'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b0, '0);
    // An inside-out rectangle must never be hit.
    add_row(mk(CMD_ADD, 1'b0, 12'd0, 12'd0, 8'd17, 16'sd100, 16'sd0, 16'sd50, 16'sd320),
            1, 1'b0, '0);
    add_row(mk(CMD_SAMPLE, 1'b1, 12'd4095, 12'd4095, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b0, '0);
    add_row(mk(CMD_SAMPLE, 1'b1, 12'd2900, 12'd1000, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b0, '0);
    add_row(mk(CMD_SAMPLE, 1'b0, 12'd0, 12'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b0, '0);
    add_row(mk(CMD_CLEAR, 1'b0, 12'd0, 12'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_OK));
    // Fill every slot with the same id, then one more add is refused.
    add_row(mk(CMD_ADD, 1'b0, 12'd0, 12'd0, 8'd9, 16'sd10, 16'sd10, 16'sd200, 16'sd300),
            TABLE_DEPTH, 1'b0, '0);
    add_row(mk(CMD_ADD, 1'b0, 12'd0, 12'd0, 8'd42, 16'sd0, 16'sd0, 16'sd10, 16'sd10),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_FULL));
    add_row(mk(CMD_REMOVE, 1'b0, 12'd0, 12'd0, 8'd9, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_OK));
    add_row(mk(CMD_REMOVE, 1'b0, 12'd0, 12'd0, 8'd42, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_NOT_FOUND));
    add_row(mk(CMD_SAMPLE, 1'b1, 12'd2000, 12'd2000, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b0, '0);
    add_row(mk(CMD_SAMPLE, 1'b0, 12'd0, 12'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_OK));
    add_row(mk(CMD_CLEAR, 1'b0, 12'd0, 12'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
            1, 1'b1, res(8'd0, 1'b0, 16'sd0, 16'sd0, ST_OK));

    // Reset is held low from the start and released on a falling edge.
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = 25;
    foreach (drills[i]) begin
      repeat (drills[i].reps) send_item(drills[i].stim, drills[i].fixed, drills[i].outcome);
    end

    // Random phases: the sender idles a quarter of the time, then just over half, then
    // never. Each phase starts from a drained block with a fresh screen size, covering
    // both extremes, zero on either axis, a random size and finally the reset values.
    for (ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 25 : (ph < 4) ? 54 : 0;
      case (ph)
        0: set_screen(10'd1023, 10'd1023, 1'b0);
        1: set_screen(10'd1, 10'd1, 1'b0);
        2: set_screen(10'd0, 10'd1023, 1'b1);
        3: set_screen(10'd1023, 10'd0, 1'b0);
        4: set_screen(scale_t'($urandom_range(1, 1023)), scale_t'($urandom_range(1, 1023)),
                      1'b1);
        default: set_screen(WIDTH_RESET, HEIGHT_RESET, 1'b0);
      endcase
      run_traffic(items_sent + PHASE_ITEMS);
    end

    // Let the last results drain, then allow a full search time for any stray strobe.
    wait_quiet();
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    while (awaited_outcomes.size() != 0) begin
      void'(awaited_outcomes.pop_front());
      report_mismatch("expected result never arrived");
    end
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
